[design/crc16fc_pkg.sv]
`default_nettype none

package crc16fc_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_CRC_INIT    = 2'd0,
    REG_CRC_POLY    = 2'd1,
    REG_HEADER_SKIP = 2'd2,
    REG_TAIL_SKIP   = 2'd3
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  // register reset values
  localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST    = 16'hA001;
  localparam logic [3:0]  HEADER_SKIP_RST = 4'd4;
  localparam logic [2:0]  TAIL_SKIP_RST   = 3'd4;

  // byte counter saturates here
  localparam logic [4:0]  BYTE_CNT_MAX    = 5'd31;

  typedef struct packed {
    logic [15:0] crc_init;
    logic [15:0] crc_poly;
    logic [3:0]  header_skip;
    logic [2:0]  tail_skip;
  } cfg_t;

  // holdback line status for the current byte
  typedef struct packed {
    logic        fold;
    logic [7:0]  fold_data;
    logic        full;
    logic [15:0] rx;
  } hb_stat_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } res_t;

endpackage

`default_nettype wire

[design/crc16fc_cfg_regs.sv]
`default_nettype none

module crc16fc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output crc16fc_pkg::cfg_t cfg
);
  import crc16fc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_init    <= CRC_INIT_RST;
      cfg_r.crc_poly    <= CRC_POLY_RST;
      cfg_r.header_skip <= HEADER_SKIP_RST;
      cfg_r.tail_skip   <= TAIL_SKIP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CRC_INIT:    cfg_r.crc_init    <= cfg_data;
        REG_CRC_POLY:    cfg_r.crc_poly    <= cfg_data;
        REG_HEADER_SKIP: cfg_r.header_skip <= cfg_data[3:0];
        REG_TAIL_SKIP:   cfg_r.tail_skip   <= cfg_data[2:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/crc16fc_in_stage.sv]
`default_nettype none

module crc16fc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_free,
  output logic       step,
  output logic [7:0] byte_q,
  output logic       last_q
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // a held byte moves on unless it is a last byte facing a full result slot
  assign step     = vld_r && (!last_r || out_free);
  assign in_ready = !vld_r || step;
  assign byte_q   = byte_r;
  assign last_q   = last_r;

  // input valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

endmodule

`default_nettype wire

[design/crc16fc_holdback.sv]
`default_nettype none

module crc16fc_holdback #(
  parameter int MAX_HOLDBACK = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  take,
  input  logic                  last,
  input  logic [7:0]            data,
  input  logic [2:0]            tail_skip,
  output crc16fc_pkg::hb_stat_t stat
);
  import crc16fc_pkg::*;

  localparam int FW = $clog2(MAX_HOLDBACK + 1);
  localparam int CW = (FW > 4) ? FW : 4;

  logic [7:0]    hb_r   [MAX_HOLDBACK];
  logic [7:0]    hb_nxt [MAX_HOLDBACK];
  logic [7:0]    up     [MAX_HOLDBACK];
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_upd;
  logic [FW-1:0] fill_nxt;
  logic [CW-1:0] depth_raw;
  logic [CW-1:0] depth;
  logic          full_now;
  logic          shift;
  logic          append;

  // neighbor taps of the shift line, the top entry sees the new byte
  for (genvar g = 0; g < MAX_HOLDBACK; g++) begin : g_up
    if (g == MAX_HOLDBACK - 1) begin : g_top
      assign up[g] = data;
    end else begin : g_mid
      assign up[g] = hb_r[g+1];
    end
  end

  // depth is two crc bytes plus the trailer, clipped to the line length
  always_comb begin
    depth_raw = CW'(tail_skip) + CW'(2);
    depth     = (depth_raw > CW'(MAX_HOLDBACK)) ? CW'(MAX_HOLDBACK) : depth_raw;
    full_now  = CW'(fill_r) >= depth;
    shift     = take && full_now;
    append    = take && !full_now && (fill_r < FW'(MAX_HOLDBACK));
    fill_upd  = append ? fill_r + FW'(1) : fill_r;
    fill_nxt  = last ? '0 : fill_upd;
  end

  // entry updates: shift out the oldest byte or append at the fill point
  always_comb begin
    for (int i = 0; i < MAX_HOLDBACK; i++) begin
      hb_nxt[i] = hb_r[i];
      if (shift) begin
        if (FW'(i + 1) < fill_r) begin
          hb_nxt[i] = up[i];
        end else if (FW'(i + 1) == fill_r) begin
          hb_nxt[i] = data;
        end
      end
      if (append && (FW'(i) == fill_r)) begin
        hb_nxt[i] = data;
      end
    end
  end

  // status toward the crc logic
  always_comb begin
    stat.fold      = shift;
    stat.fold_data = hb_r[0];
    stat.full      = CW'(fill_upd) >= depth;
    stat.rx        = {hb_nxt[0], hb_nxt[1]};
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (step) begin
      fill_r <= fill_nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_HOLDBACK; i++) begin
        hb_r[i] <= hb_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[design/crc16fc_check.sv]
`default_nettype none

module crc16fc_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crc16fc_pkg::cfg_t     cfg,
  input  logic                  step,
  input  logic                  last,
  input  crc16fc_pkg::hb_stat_t hb,
  output logic                  take,
  output logic                  res_vld,
  output crc16fc_pkg::res_t     res
);
  import crc16fc_pkg::*;

  logic [15:0] acc_r;
  logic [15:0] acc_nxt;
  logic [15:0] base;
  logic [4:0]  cnt_r;
  logic [4:0]  cnt_nxt;

  // msb-first fold of one byte, eight shift steps
  function automatic logic [15:0] fold_byte(input logic [15:0] crc,
                                            input logic [7:0]  b,
                                            input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // header bytes stay out of the holdback line
  assign take = {1'b0, cfg.header_skip} <= cnt_r;

  // crc accumulator and byte count next values
  always_comb begin
    base    = (cnt_r == '0) ? cfg.crc_init : acc_r;
    acc_nxt = hb.fold ? fold_byte(base, hb.fold_data, cfg.crc_poly) : base;
    if (last) begin
      cnt_nxt = '0;
    end else if (cnt_r == BYTE_CNT_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  // frame verdict on the last byte
  always_comb begin
    res_vld = step && last;
    if (!hb.full) begin
      res.status       = ST_SHORT;
      res.computed_crc = cfg.crc_init;
      res.received_crc = '0;
    end else begin
      res.status       = (acc_nxt == hb.rx) ? ST_MATCH : ST_MISMATCH;
      res.computed_crc = acc_nxt;
      res.received_crc = hb.rx;
    end
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  // crc accumulator, reloaded from crc_init at each frame start
  always_ff @(posedge clk) begin
    if (step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

[design/crc16fc_out_stage.sv]
`default_nettype none

module crc16fc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  crc16fc_pkg::res_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_computed_crc,
  output logic [15:0]       out_received_crc
);
  import crc16fc_pkg::*;

  logic vld_r;
  res_t res_r;

  assign out_free         = !vld_r || out_ready;
  assign out_valid        = vld_r;
  assign out_status       = res_r.status;
  assign out_computed_crc = res_r.computed_crc;
  assign out_received_crc = res_r.received_crc;

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= res_vld;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free && res_vld) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

[design/crc16_frame_checker_top.sv]
`default_nettype none

// Frame CRC checker. Bytes of a frame enter one per request with the last
// byte flagged; the first header_skip bytes are skipped, the payload is
// folded MSB-first into a CRC-16 (crc_init start, crc_poly feedback), and
// the last 2 + tail_skip bytes (at most MAX_HOLDBACK) are held back so the
// big-endian CRC field in front of the trailer can be compared at the end.
// One result request comes out per frame: match, mismatch, or too short
// when the frame has fewer than header_skip plus the held-back bytes. A byte
// is accepted every cycle unless a last byte waits for a full result slot;
// an accepted last byte goes through the input register, then the result
// register fed by the combinational byte fold, and a stalled result only
// holds back a later last byte. Write configuration only between frames.
module crc16_frame_checker_top #(
  parameter int MAX_HOLDBACK = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_computed_crc,
  output logic [15:0] out_received_crc
);
  import crc16fc_pkg::*;

  cfg_t       cfg;
  hb_stat_t   hb;
  res_t       res;
  logic       res_vld;
  logic       out_free;
  logic       step;
  logic       take;
  logic [7:0] byte_q;
  logic       last_q;

  crc16fc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc16fc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_free     (out_free),
    .step         (step),
    .byte_q       (byte_q),
    .last_q       (last_q)
  );

  crc16fc_holdback #(
    .MAX_HOLDBACK (MAX_HOLDBACK)
  ) u_hb (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .take      (take),
    .last      (last_q),
    .data      (byte_q),
    .tail_skip (cfg.tail_skip),
    .stat      (hb)
  );

  crc16fc_check u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (step),
    .last    (last_q),
    .hb      (hb),
    .take    (take),
    .res_vld (res_vld),
    .res     (res)
  );

  crc16fc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_vld          (res_vld),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_received_crc (out_received_crc)
  );

`ifndef SYNTHESIS
  // a verdict is never produced while the result slot is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !res_vld)
    else $error("result produced into a blocked result register");

  // a match verdict carries equal crc fields
  a_match_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MATCH)) |-> (out_computed_crc == out_received_crc))
    else $error("match reported with differing crc values");

  // a short frame reports no received crc
  a_short_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_SHORT)) |-> (out_received_crc == 16'h0000))
    else $error("short frame with nonzero received crc");
`endif

endmodule

`default_nettype wire
